[sv/jit_pkg.sv]
// ----------------------------------------------------------------------------
// jit_pkg
// Shared constants, register indexes and helper functions of the joint
// impedance torque block.
// ----------------------------------------------------------------------------
package jit_pkg;

  localparam int unsigned NumJoints = 7;
  localparam int unsigned JointW    = 3;
  localparam int unsigned JointAw   = (NumJoints > 1) ? $clog2(NumJoints) : 1;
  localparam int unsigned NumSlots  = 1 << JointAw;
  localparam int unsigned FiltW     = 32;
  localparam int unsigned GainW     = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned NumStg    = 8;

  // filter weights in Q0.16
  localparam logic [15:0] AlphaQ16         = 16'd64881;
  localparam logic [9:0]  OneMinusAlphaQ16 = 10'd655;

  localparam logic [15:0] CorScaleRst = 16'd16384;
  localparam logic [30:0] MaxStepRst  = 31'd65536;

  typedef logic [JointW-1:0] joint_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STIFF_LO = 3'd0,
    CFG_STIFF_HI = 3'd1,
    CFG_DAMP_LO  = 3'd2,
    CFG_DAMP_HI  = 3'd3,
    CFG_COR_SCL  = 3'd4,
    CFG_MAX_STEP = 3'd5
  } cfg_idx_e;

  // joint has a filter slot
  function automatic logic joint_stored(input joint_t j);
    return (32'(j) < NumJoints);
  endfunction

  // gain of one joint out of the packed low/high registers
  function automatic logic [GainW-1:0] gain_sel(input logic [63:0] lo,
                                                input logic [47:0] hi,
                                                input joint_t      j);
    logic [GainW-1:0] g;
    case (j)
      3'd0:    g = lo[15:0];
      3'd1:    g = lo[31:16];
      3'd2:    g = lo[47:32];
      3'd3:    g = lo[63:48];
      3'd4:    g = hi[15:0];
      3'd5:    g = hi[31:16];
      3'd6:    g = hi[47:32];
      default: g = '0;
    endcase
    return g;
  endfunction

  // saturate a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[sv/jit_ram.sv]
// ----------------------------------------------------------------------------
// jit_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module jit_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/joint_impedance_torque.sv]
// ----------------------------------------------------------------------------
// joint_impedance_torque
// Per-joint impedance torque with a filtered velocity per joint and a rate
// limit against the prior command.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_ready_o    joint_i .. prior_torque_i
//  out       output     out_valid_o / out_ready_i  joint_out_o, torque_command_o
//  cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One request per cycle unless the output stalls or a same-joint request is held;
// results pass through an 8-stage pipeline and an output register.
// The filtered velocity lives in a RAM read as each request enters stage 1; a
// request for the joint just ahead of it waits in stage 1 until that one moves on.
// Reset clears the per-joint valid bits, so the filter starts from zero; no
// clearing pass. Every stage is elastic: bubbles close up under a stalled output.
// ----------------------------------------------------------------------------
module joint_impedance_torque (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jit_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [jit_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  jit_pkg::joint_t               joint_i,
  input  logic signed [31:0]            position_i,
  input  logic signed [31:0]            target_position_i,
  input  logic signed [31:0]            velocity_i,
  input  logic signed [31:0]            target_velocity_i,
  input  logic signed [31:0]            coriolis_torque_i,
  input  logic signed [31:0]            prior_torque_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output jit_pkg::joint_t               joint_out_o,
  output logic signed [31:0]            torque_command_o
);

  import jit_pkg::*;

  // configuration
  logic [63:0] stiff_lo_q, damp_lo_q;
  logic [47:0] stiff_hi_q, damp_hi_q;
  logic [15:0] cor_scale_q;
  logic [30:0] max_step_q;

  // pipeline control
  logic [NumStg-1:0] v_q, v_d, mv, ok;
  logic              out_valid_q, out_valid_d;
  logic              accept, hazard;

  // filter memory
  logic [NumSlots-1:0] fv_vld_q;
  logic                rd_vld_q;
  logic [JointAw-1:0]  rd_addr, wr_addr;
  logic [FiltW-1:0]    rd_data;
  logic                wr_en;

  // stage registers
  joint_t s1_joint_q, s2_joint_q, s3_joint_q, s4_joint_q;
  joint_t s5_joint_q, s6_joint_q, s7_joint_q, s8_joint_q;
  logic signed [48:0] s1_pv_q, s1_cp_q, s2_pv_q;
  logic signed [32:0] s1_ep_q;
  logic signed [31:0] s1_tv_q, s2_tv_q, s3_tv_q;
  logic signed [31:0] s1_pr_q, s2_pr_q, s3_pr_q, s4_pr_q;
  logic signed [31:0] s5_pr_q, s6_pr_q, s7_pr_q, s8_pr_q;
  logic signed [42:0] s2_po_q;
  logic signed [49:0] s2_kp_q;
  logic signed [34:0] s2_cr_q, s3_cr_q;
  logic signed [31:0] s3_f_q;
  logic signed [43:0] s3_kr_q;
  logic signed [32:0] s4_dv_q;
  logic signed [44:0] s4_ck_q, s5_ck_q;
  logic signed [49:0] s5_dp_q;
  logic signed [45:0] s6_tau_q;
  logic signed [46:0] s7_df_q;
  logic signed [31:0] s8_dc_q;
  joint_t             joint_out_q;
  logic signed [31:0] torque_q;

  // stage logic
  logic signed [48:0] s1_pv_d, s1_cp_d;
  logic signed [32:0] s1_ep_d;
  logic signed [31:0] old_f;
  logic [GainW-1:0]   k_gain, d_gain;
  logic signed [42:0] s2_po_d;
  logic signed [49:0] s2_kp_d;
  logic signed [48:0] cp_rnd;
  logic signed [34:0] s2_cr_d;
  logic signed [48:0] f_sum;
  logic signed [31:0] s3_f_d;
  logic signed [49:0] kp_rnd;
  logic signed [43:0] s3_kr_d;
  logic signed [32:0] s4_dv_d;
  logic signed [44:0] s4_ck_d;
  logic signed [49:0] s5_dp_d;
  logic signed [49:0] dp_rnd;
  logic signed [43:0] dr;
  logic signed [45:0] s6_tau_d;
  logic signed [46:0] s7_df_d;
  logic signed [46:0] step_s;
  logic signed [31:0] s8_dc_d;
  logic signed [32:0] res_sum;
  logic signed [31:0] torque_d;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_lo_q  <= '0;
      stiff_hi_q  <= '0;
      damp_lo_q   <= '0;
      damp_hi_q   <= '0;
      cor_scale_q <= CorScaleRst;
      max_step_q  <= MaxStepRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STIFF_LO: stiff_lo_q  <= cfg_data_i;
        CFG_STIFF_HI: stiff_hi_q  <= cfg_data_i[47:0];
        CFG_DAMP_LO:  damp_lo_q   <= cfg_data_i;
        CFG_DAMP_HI:  damp_hi_q   <= cfg_data_i[47:0];
        CFG_COR_SCL:  cor_scale_q <= cfg_data_i[15:0];
        CFG_MAX_STEP: max_step_q  <= cfg_data_i[30:0];
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // elastic pipeline control
  // ---------------------------------------------------------------------------
  // the older sample of the same joint has not written its filter value yet
  assign hazard = v_q[1] && (s2_joint_q == s1_joint_q) && joint_stored(s1_joint_q);

  always_comb begin
    logic nxt_ok;
    nxt_ok = !out_valid_q || out_ready_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      mv[k]  = v_q[k] && nxt_ok && !((k == 0) && hazard);
      ok[k]  = !v_q[k] || mv[k];
      nxt_ok = ok[k];
    end
  end

  assign in_ready_o = ok[0];
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    v_d[0] = accept || (v_q[0] && !mv[0]);
    for (int k = 1; k < NumStg; k++) begin
      v_d[k] = mv[k-1] || (v_q[k] && !mv[k]);
    end
    out_valid_d = mv[NumStg-1] || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v_q         <= v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // filtered velocity store
  // ---------------------------------------------------------------------------
  // read the joint about to sit in stage 1, or keep reading the one there
  assign rd_addr = accept ? JointAw'(joint_i) : JointAw'(s1_joint_q);
  assign wr_en   = mv[1] && joint_stored(s2_joint_q);
  assign wr_addr = JointAw'(s2_joint_q);

  jit_ram #(
    .Width (FiltW),
    .Depth (NumJoints)
  ) u_fv_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (s3_f_d),
    .re_i    (1'b1),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_vld_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= fv_vld_q[rd_addr];
      if (wr_en) begin
        fv_vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  // stage 3 holds the newest write for its joint; ram data misses the last write
  always_comb begin
    if (!joint_stored(s1_joint_q)) begin
      old_f = '0;
    end else if (v_q[2] && (s3_joint_q == s1_joint_q)) begin
      old_f = s3_f_q;
    end else if (rd_vld_q) begin
      old_f = rd_data;
    end else begin
      old_f = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_pv_d = $signed({1'b0, AlphaQ16}) * velocity_i;
    s1_cp_d = $signed({1'b0, cor_scale_q}) * coriolis_torque_i;
    s1_ep_d = 33'(target_position_i) - 33'(position_i);

    k_gain  = gain_sel(stiff_lo_q, stiff_hi_q, s1_joint_q);
    s2_po_d = $signed({1'b0, OneMinusAlphaQ16}) * old_f;
    s2_kp_d = $signed({1'b0, k_gain}) * s1_ep_q;
    cp_rnd  = s1_cp_q + 49'sd8192;
    s2_cr_d = cp_rnd[48:14];

    f_sum   = s2_pv_q + 49'(s2_po_q) + 49'sd32768;
    s3_f_d  = sat32(f_sum[48:16]);
    kp_rnd  = s2_kp_q + 50'sd32;
    s3_kr_d = kp_rnd[49:6];

    s4_dv_d = 33'(s3_tv_q) - 33'(s3_f_q);
    s4_ck_d = 45'(s3_cr_q) + 45'(s3_kr_q);

    d_gain  = gain_sel(damp_lo_q, damp_hi_q, s4_joint_q);
    s5_dp_d = $signed({1'b0, d_gain}) * s4_dv_q;

    dp_rnd   = s5_dp_q + 50'sd32;
    dr       = dp_rnd[49:6];
    s6_tau_d = 46'(s5_ck_q) + 46'(dr);

    s7_df_d = 47'(s6_tau_q) - 47'(s6_pr_q);

    // clamp the change against the prior command
    step_s = $signed(47'(max_step_q));
    if (s7_df_q > step_s) begin
      s8_dc_d = 32'(step_s);
    end else if (s7_df_q < -step_s) begin
      s8_dc_d = 32'(-step_s);
    end else begin
      s8_dc_d = 32'(s7_df_q);
    end

    res_sum  = 33'(s8_pr_q) + 33'(s8_dc_q);
    torque_d = sat32(res_sum);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_joint_q <= joint_i;
      s1_pv_q    <= s1_pv_d;
      s1_cp_q    <= s1_cp_d;
      s1_ep_q    <= s1_ep_d;
      s1_tv_q    <= target_velocity_i;
      s1_pr_q    <= prior_torque_i;
    end
    if (mv[0]) begin
      s2_joint_q <= s1_joint_q;
      s2_pv_q    <= s1_pv_q;
      s2_po_q    <= s2_po_d;
      s2_kp_q    <= s2_kp_d;
      s2_cr_q    <= s2_cr_d;
      s2_tv_q    <= s1_tv_q;
      s2_pr_q    <= s1_pr_q;
    end
    if (mv[1]) begin
      s3_joint_q <= s2_joint_q;
      s3_f_q     <= s3_f_d;
      s3_cr_q    <= s2_cr_q;
      s3_kr_q    <= s3_kr_d;
      s3_tv_q    <= s2_tv_q;
      s3_pr_q    <= s2_pr_q;
    end
    if (mv[2]) begin
      s4_joint_q <= s3_joint_q;
      s4_dv_q    <= s4_dv_d;
      s4_ck_q    <= s4_ck_d;
      s4_pr_q    <= s3_pr_q;
    end
    if (mv[3]) begin
      s5_joint_q <= s4_joint_q;
      s5_dp_q    <= s5_dp_d;
      s5_ck_q    <= s4_ck_q;
      s5_pr_q    <= s4_pr_q;
    end
    if (mv[4]) begin
      s6_joint_q <= s5_joint_q;
      s6_tau_q   <= s6_tau_d;
      s6_pr_q    <= s5_pr_q;
    end
    if (mv[5]) begin
      s7_joint_q <= s6_joint_q;
      s7_df_q    <= s7_df_d;
      s7_pr_q    <= s6_pr_q;
    end
    if (mv[6]) begin
      s8_joint_q <= s7_joint_q;
      s8_dc_q    <= s8_dc_d;
      s8_pr_q    <= s7_pr_q;
    end
    if (mv[7]) begin
      joint_out_q <= s8_joint_q;
      torque_q    <= torque_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign joint_out_o      = joint_out_q;
  assign torque_command_o = torque_q;

endmodule

[tb/joint_impedance_torque_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_impedance_torque_tb
// Sends joint samples through the torque block under several register
// settings. The expected torque command of every request is worked out when
// it is accepted and compared with the results in order. Both sides idle at
// random outside steady settings; the output side also holds off for long stretches.
// ----------------------------------------------------------------------------
module joint_impedance_torque_tb;
  import jit_pkg::*;

  localparam int          HalfPeriod    = 5;
  localparam int          TotalSamples  = 1300;
  localparam int          LongHold      = 300;
  localparam int          DrainCycles   = 20;
  localparam int unsigned JointSlots    = 7;
  localparam longint      FiltWeightNew = 64881;
  localparam longint      FiltWeightOld = 655;
  localparam longint      LongMax       = 64'sd2147483647;
  localparam longint      LongMin       = -64'sd2147483648;
  localparam logic [31:0] WordMax       = 32'h7fff_ffff;
  localparam logic [31:0] WordMin       = 32'h8000_0000;
  localparam logic [31:0] OneNm         = 32'h0001_0000;
  // indexes past the register list, writes there are dropped
  localparam logic [2:0]  CfgSpareLo    = 3'd6;
  localparam logic [2:0]  CfgSpareHi    = 3'd7;

  typedef struct {
    joint_t             joint;
    logic signed [31:0] position, target_position, velocity, target_velocity;
    logic signed [31:0] coriolis, prior;
  } joint_sample_t;

  typedef struct {
    joint_t             joint;
    logic signed [31:0] torque;
  } torque_cmd_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we          = 1'b0;
  logic [2:0]         cfg_index       = '0;
  logic [63:0]        cfg_data        = '0;
  logic               in_valid        = 1'b0;
  logic               in_ready;
  joint_t             joint           = '0;
  logic signed [31:0] position        = '0;
  logic signed [31:0] target_position = '0;
  logic signed [31:0] velocity        = '0;
  logic signed [31:0] target_velocity = '0;
  logic signed [31:0] coriolis_torque = '0;
  logic signed [31:0] prior_torque    = '0;
  logic               out_valid;
  logic               out_ready       = 1'b0;
  joint_t             joint_out;
  logic signed [31:0] torque_command;

  // register copies and per-joint filter state of the predictor
  logic [63:0]        stiff_lo   = '0;
  logic [47:0]        stiff_hi   = '0;
  logic [63:0]        damp_lo    = '0;
  logic [47:0]        damp_hi    = '0;
  logic [15:0]        cor_scale  = 16'd16384;
  logic [30:0]        step_limit = 31'd65536;
  logic signed [31:0] filt_vel [JointSlots];

  joint_sample_t sample_q[$];
  torque_cmd_t   torque_due_q[$];
  joint_sample_t cur_sample;

  int  issued_cnt   = 0;
  int  accepted_cnt = 0;
  int  checked_cnt  = 0;
  int  err_cnt      = 0;
  int  setting_cnt  = 0;
  int  hold_cnt     = 0;
  int  send_gap     = 0;
  int  recv_gap     = 0;
  int  hold_left    = 0;
  int  next_hold_at = 300;
  bit  steady       = 1'b0;

  joint_impedance_torque uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .joint_i           (joint),
    .position_i        (position),
    .target_position_i (target_position),
    .velocity_i        (velocity),
    .target_velocity_i (target_velocity),
    .coriolis_torque_i (coriolis_torque),
    .prior_torque_i    (prior_torque),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .joint_out_o       (joint_out),
    .torque_command_o  (torque_command)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic longint sat_word(input longint x);
    if (x > LongMax) return LongMax;
    if (x < LongMin) return LongMin;
    return x;
  endfunction

  // add half an lsb, then floor
  function automatic longint round_down(input longint x, input int sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint joint_gain(input logic [63:0] lo, input logic [47:0] hi,
                                        input joint_t j);
    if (j < 4) return longint'(lo[16*j +: 16]);
    if (j < 7) return longint'(hi[16*(j-4) +: 16]);
    return 0;
  endfunction

  // also advances the filtered velocity of the joint
  function automatic torque_cmd_t predict_torque(input joint_sample_t s);
    torque_cmd_t r;
    longint      old_f, new_f, tau, diff, lim;
    old_f = 0;
    if (s.joint < JointSlots) old_f = longint'(filt_vel[s.joint]);
    new_f = sat_word(round_down(FiltWeightOld * old_f + FiltWeightNew * longint'(s.velocity),
                                16));
    if (s.joint < JointSlots) filt_vel[s.joint] = 32'(new_f);
    tau = round_down(longint'(cor_scale) * longint'(s.coriolis), 14)
        + round_down(joint_gain(stiff_lo, stiff_hi, s.joint)
                     * (longint'(s.target_position) - longint'(s.position)), 6)
        + round_down(joint_gain(damp_lo, damp_hi, s.joint)
                     * (longint'(s.target_velocity) - new_f), 6);
    diff = tau - longint'(s.prior);
    lim  = longint'(step_limit);
    if (diff > lim) diff = lim;
    if (diff < -lim) diff = -lim;
    r.joint  = s.joint;
    r.torque = 32'(sat_word(longint'(s.prior) + diff));
    return r;
  endfunction

  function automatic int idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0:       return WordMax;
      1:       return WordMin;
      2, 3, 4: return r;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  function automatic logic [31:0] near_word(input logic [31:0] base);
    logic [31:0] r;
    r = $urandom();
    return base + {{16{r[15]}}, r[15:0]};
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 255));
      3, 4:    return 16'($urandom_range(0, 4095));
      5:       return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [63:0] gain_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {pick_gain(), pick_gain(), pick_gain(), pick_gain()};
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_STIFF_LO: stiff_lo   = val;
      CFG_STIFF_HI: stiff_hi   = val[47:0];
      CFG_DAMP_LO:  damp_lo    = val;
      CFG_DAMP_HI:  damp_hi    = val[47:0];
      CFG_COR_SCL:  cor_scale  = val[15:0];
      CFG_MAX_STEP: step_limit = val[30:0];
      default: ;
    endcase
  endtask

  task automatic add_sample(input joint_t j, input logic [31:0] pos, tpos, vel, tvel,
                            input logic [31:0] cor, prior);
    joint_sample_t s;
    s.joint           = j;
    s.position        = pos;
    s.target_position = tpos;
    s.velocity        = vel;
    s.target_velocity = tvel;
    s.coriolis        = cor;
    s.prior           = prior;
    sample_q.insert(sample_q.size(), s);
    issued_cnt++;
  endtask

  // sender pause: nothing left to offer and every result back
  task automatic wait_all_done();
    while (!(accepted_cnt == issued_cnt && torque_due_q.size() == 0)) @(posedge clk_i);
  endtask

  task automatic load_setting(input bit minimal);
    logic [63:0] junk;
    logic [63:0] gw;
    logic [15:0] scl;
    logic [30:0] lim;
    junk = {$urandom(), $urandom()};
    if (minimal) begin
      write_reg(CFG_STIFF_LO, '0);
      write_reg(CFG_STIFF_HI, {16'hffff, 48'h0});
      write_reg(CFG_DAMP_LO, '0);
      write_reg(CFG_DAMP_HI, {16'hffff, 48'h0});
      write_reg(CFG_COR_SCL, {48'hffff_ffff_ffff, 16'h0});
      write_reg(CFG_MAX_STEP, {33'h1_ffff_ffff, 31'h0});
    end else begin
      case ($urandom_range(0, 5))
        0:       scl = '0;
        1:       scl = '1;
        2:       scl = 16'd16384;
        default: scl = 16'($urandom());
      endcase
      case ($urandom_range(0, 5))
        0:       lim = '0;
        1:       lim = '1;
        2, 3:    lim = 31'($urandom_range(0, 32'h0004_0000));
        default: lim = 31'($urandom());
      endcase
      write_reg(CFG_STIFF_LO, gain_word());
      gw = gain_word();
      write_reg(CFG_STIFF_HI, {junk[63:48], gw[47:0]});
      write_reg(CFG_DAMP_LO, gain_word());
      gw = gain_word();
      write_reg(CFG_DAMP_HI, {junk[47:32], gw[47:0]});
      write_reg(CFG_COR_SCL, {junk[63:16], scl});
      write_reg(CFG_MAX_STEP, {junk[63:31], lim});
    end
    write_reg(CfgSpareLo, {$urandom(), $urandom()});
    write_reg(CfgSpareHi, {$urandom(), $urandom()});
    setting_cnt++;
  endtask

  task automatic add_random_samples(input int count);
    joint_t      j;
    logic [31:0] pos, tpos, vel, tvel;
    j = '0;
    for (int n = 0; n < count; n++) begin
      // runs on one joint exercise the filter read-after-write path
      if ($urandom_range(0, 99) >= 30) begin
        j = ($urandom_range(0, 99) < 8) ? joint_t'(3'd7) : joint_t'($urandom_range(0, 6));
      end
      pos  = pick_word();
      tpos = $urandom_range(0, 1) ? near_word(pos) : pick_word();
      vel  = pick_word();
      tvel = $urandom_range(0, 1) ? near_word(vel) : pick_word();
      add_sample(j, pos, tpos, vel, tvel, pick_word(), pick_word());
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic offering;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        torque_due_q.insert(torque_due_q.size(), predict_torque(cur_sample));
        accepted_cnt++;
        offering = 1'b0;
        send_gap = steady ? 0 : idle_len();
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_q.size() > 0) begin
          cur_sample = sample_q.pop_front();
          joint           <= cur_sample.joint;
          position        <= cur_sample.position;
          target_position <= cur_sample.target_position;
          velocity        <= cur_sample.velocity;
          target_velocity <= cur_sample.target_velocity;
          coriolis_torque <= cur_sample.coriolis;
          prior_torque    <= cur_sample.prior;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    torque_cmd_t due;
    logic        ready_next;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        checked_cnt++;
        if (!steady) recv_gap = idle_len();
        if (torque_due_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected: joint %0d torque %0d",
                   $time, joint_out, torque_command);
        end else begin
          due = torque_due_q.pop_front();
          if (joint_out !== due.joint) begin
            err_cnt++;
            $display("%0t: joint_out mismatch: expected %0d, actual %0d",
                     $time, due.joint, joint_out);
          end
          if (torque_command !== due.torque) begin
            err_cnt++;
            $display("%0t: torque_command mismatch (joint %0d): expected %0d, actual %0d",
                     $time, due.joint, due.torque, torque_command);
          end
        end
      end
      // long hold-off while requests keep coming, so the pipeline backs up
      if (hold_left == 0 && checked_cnt >= next_hold_at && sample_q.size() > 40) begin
        hold_left = LongHold;
        next_hold_at += 500;
        hold_cnt++;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (steady) begin
        ready_next = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  initial begin
    filt_vel = '{default: '0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register values after reset: no gains, unit Coriolis scale, unit step
    add_sample(3'd0, '0, '0, '0, '0, '0, '0);
    add_sample(3'd6, WordMax, WordMin, WordMax, WordMin, WordMax, '0);
    add_sample(3'd6, WordMin, WordMax, WordMin, WordMax, WordMin, WordMax);
    add_sample(3'd7, WordMax, WordMin, WordMax, '0, 32'h0005_0000, WordMax);
    add_sample(3'd3, '0, '0, '0, '0, WordMax, 32'h7fff_ff00);
    add_sample(3'd2, '0, '0, '0, '0, WordMin, 32'h8000_0100);
    add_sample(3'd1, '0, '0, WordMax, '0, OneNm, '0);
    add_sample(3'd1, '0, '0, WordMax, '0, OneNm, '0);
    add_sample(3'd1, '0, '0, WordMin, WordMax, '0, '0);
    setting_cnt++;
    wait_all_done();

    // every register at its top value, high junk bits masked off
    write_reg(CFG_STIFF_LO, '1);
    write_reg(CFG_STIFF_HI, '1);
    write_reg(CFG_DAMP_LO, '1);
    write_reg(CFG_DAMP_HI, '1);
    write_reg(CFG_COR_SCL, '1);
    write_reg(CFG_MAX_STEP, '1);
    write_reg(CfgSpareLo, '0);
    write_reg(CfgSpareHi, '1);
    setting_cnt++;
    add_sample(3'd0, WordMin, WordMax, '0, WordMax, WordMax, OneNm);
    add_sample(3'd0, WordMin, WordMax, '0, WordMax, WordMax, WordMax);
    add_sample(3'd4, WordMax, WordMin, WordMax, WordMin, WordMin, WordMin);
    add_sample(3'd4, WordMax, WordMin, WordMax, WordMin, WordMin, 32'hffff_0000);
    add_sample(3'd5, WordMin, WordMin, WordMin, WordMin, WordMin, '0);
    add_sample(3'd6, WordMax, WordMax, WordMax, WordMax, WordMax, '0);
    add_sample(3'd7, WordMin, WordMax, WordMin, WordMax, OneNm, '0);
    add_sample(3'd3, 32'h0001_8000, 32'h0001_0000, 32'h0004_0000, '0, '0, '0);
    add_sample(3'd3, 32'h0001_8000, 32'h0001_0000, 32'hfffc_0000, '0, '0, '0);
    add_sample(3'd3, '0, '0, '0, '0, '0, '0);
    add_sample(3'd2, 32'hffff_ffff, '0, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, '0);
    wait_all_done();

    while (issued_cnt < TotalSamples) begin
      steady = (setting_cnt % 3 == 2);
      load_setting(setting_cnt == 2);
      add_random_samples($urandom_range(100, 200));
      wait_all_done();
    end
    steady = 1'b0;

    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d joint samples under %0d register settings, %0d long output holds",
             accepted_cnt, setting_cnt, hold_cnt);
    $display("checked %0d torque commands, %0d mismatches", checked_cnt, err_cnt);
    if (err_cnt == 0 && torque_due_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d of %0d requests accepted, %0d results outstanding",
             accepted_cnt, issued_cnt, torque_due_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
sv/jit_pkg.sv
sv/jit_ram.sv
sv/joint_impedance_torque.sv
tb/joint_impedance_torque_tb.sv
